// ===== sv/dsc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the distinct subsequence counter.
package dsc_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int CNT_W       = 32;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int SEL_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 8'd0,
        REG_PATTERN_HIGH = 8'd1,
        REG_PATTERN_LEN  = 8'd2
    } cfg_reg_t;

    // Broadcast to every cell in the chain
    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              clear;
        logic              fire;
    } cell_ctrl_t;

endpackage

// ===== sv/distinct_subsequence_counter.sv =====
`timescale 1ns / 1ps
// Distinct subsequence counter top level: config, chain of prefix cells, output register.
//
// Use: write the pattern through the cfg channel while no text is in flight:
// index 0 takes pattern bytes 0..7 (byte 0 lowest), index 1 bytes 8..15,
// index 2 the pattern length (bits 4:0 only; 17..31 act as 16). Other indices
// are ignored. cfg_ready is always high.
// Text bytes arrive on the s_ channel: tdata is the byte, tuser set clears
// every prefix count before the byte is used, tlast marks the final byte.
// Every accepted byte yields one result on the m_ channel: tdata is the
// count of the full pattern as a subsequence so far (modulo 2^32), tlast
// copies the input tlast. An empty pattern yields 0.
// m_tvalid rises in the cycle after the input transfer. One byte per cycle
// is sustained: all sixteen cells update together from their neighbours'
// old counts, and the single output register is refilled in the cycle it
// is drained. If the receiver stalls, s_tready drops until the held result
// is taken. Reset clears the pattern, the length and all counts.
module distinct_subsequence_counter (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dsc_pkg::CFG_DATA_W-1:0]   cfg_data,
    // text input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] text_byte
    input  logic                             s_tuser,   // [0] start_text
    input  logic                             s_tlast,   // end_text
    // results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // [31:0] match_count
    output logic                             m_tlast    // is_final
);

    localparam int N = dsc_pkg::PATTERN_MAX;

    logic [dsc_pkg::CFG_DATA_W-1:0] pat_low_reg;
    logic [dsc_pkg::CFG_DATA_W-1:0] pat_high_reg;
    logic [dsc_pkg::LEN_W-1:0]      pat_len_reg;
    logic [dsc_pkg::LEN_W-1:0]      len_eff;
    logic [2*dsc_pkg::CFG_DATA_W-1:0] pat_all;

    logic                           fire;
    dsc_pkg::cell_ctrl_t            ctrl;

    logic [N-1:0][dsc_pkg::CNT_W-1:0] bases;
    logic [N-1:0][dsc_pkg::CNT_W-1:0] nexts;
    logic [N-1:0][dsc_pkg::CNT_W-1:0] counts;
    logic [dsc_pkg::CNT_W-1:0]        result;
    logic [dsc_pkg::LEN_W-1:0]        last_idx;

    logic                           out_valid_reg;
    logic [dsc_pkg::CNT_W-1:0]      out_count_reg;
    logic                           out_last_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dsc_pkg::REG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                dsc_pkg::REG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                dsc_pkg::REG_PATTERN_LEN:  pat_len_reg  <= cfg_data[dsc_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign len_eff = (pat_len_reg > dsc_pkg::LEN_W'(N)) ? dsc_pkg::LEN_W'(N) : pat_len_reg;
    assign pat_all = {pat_high_reg, pat_low_reg};

    // accept a byte whenever the output slot is free or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;

    assign ctrl.text_byte = s_tdata;
    assign ctrl.clear     = s_tuser;
    assign ctrl.fire      = fire;

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        logic [dsc_pkg::CNT_W-1:0] shorter;
        if (k == 0)
        begin : g_head
            assign shorter = dsc_pkg::CNT_W'(1);   // empty prefix
        end
        else
        begin : g_body
            assign shorter = bases[k-1];
        end

        dsc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .active     (dsc_pkg::LEN_W'(k) < len_eff),
            .pat_byte   (pat_all[8*k +: 8]),
            .shorter    (shorter),
            .base       (bases[k]),
            .count_next (nexts[k]),
            .count      (counts[k])
        );
    end

    assign last_idx = len_eff - dsc_pkg::LEN_W'(1);
    assign result   = (len_eff == '0) ? '0 : nexts[last_idx[dsc_pkg::SEL_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_count_reg <= result;
            out_last_reg  <= s_tlast;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_count_reg;
    assign m_tlast  = out_last_reg;

    // counts move only on an input transfer
    a_counts_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(counts))
        else $error("prefix counts changed without an input transfer");

    // an accepted byte always leaves a result in the output register
    a_result_ready: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid)
        else $error("accepted byte produced no result");

    // empty pattern reports zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (len_eff == '0) |=> (m_tdata == '0))
        else $error("empty pattern gave a non-zero count");

    // a clear with a non-matching first byte leaves the first prefix at zero
    a_clear_head: assert property (@(posedge clk) disable iff (!rst_n)
        fire && s_tuser && (pat_all[7:0] != s_tdata) |=> (counts[0] == '0))
        else $error("clear did not reset the first prefix count");

endmodule

// ===== sv/dsc_cell.sv =====
`timescale 1ns / 1ps
// One prefix cell: holds the count of one pattern prefix.
module dsc_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dsc_pkg::cell_ctrl_t       ctrl,
    input  logic                      active,
    input  logic [dsc_pkg::BYTE_W-1:0] pat_byte,
    input  logic [dsc_pkg::CNT_W-1:0] shorter,
    output logic [dsc_pkg::CNT_W-1:0] base,
    output logic [dsc_pkg::CNT_W-1:0] count_next,
    output logic [dsc_pkg::CNT_W-1:0] count
);

    logic [dsc_pkg::CNT_W-1:0] count_reg;
    logic                      hit;

    // old value as seen by this transfer, after an optional clear
    assign base = ctrl.clear ? '0 : count_reg;
    assign hit  = active && (pat_byte == ctrl.text_byte);

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.fire)
        begin
            count_next = hit ? (base + shorter) : base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule
